@@ hw/rtl/tksel_pkg.sv @@
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types and constants of the top-k score selector: the input and
// result words, the cell control group and the default store depth.
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int MAX_KEEP_DEF = 16;
  localparam int SCORE_W      = 32;
  localparam int DOC_W        = 32;
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0] KEEP_RESET = 5'd10;

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic               action;
    logic [DOC_W-1:0]   doc_number;
    logic [SCORE_W-1:0] doc_score;
    logic               doc_live;
  } in_word_t;

  typedef struct packed {
    logic [DOC_W-1:0]   out_doc;
    logic [SCORE_W-1:0] out_score;
    logic [SCORE_W-1:0] threshold;
    logic               accepted;
    logic               is_entry;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic ins_en;       // insert the offered word into the chain
    logic drain_shift;  // move every entry one cell toward the head
  } cell_ctl_t;

endpackage

@@ hw/rtl/tksel_cell.sv @@
// ----------------------------------------------------------------------------
// tksel_cell
// One rank slot of the sorted chain: holds a score and document number,
// compares them with the offered word and takes its own, its left or its
// right neighbor's entry, or the offered word.
// ----------------------------------------------------------------------------
module tksel_cell
  import tksel_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               occupied,
  input  logic [SCORE_W-1:0] item_score,
  input  logic [DOC_W-1:0]   item_doc,
  input  logic               left_ahead,
  input  logic [SCORE_W-1:0] left_score,
  input  logic [DOC_W-1:0]   left_doc,
  input  logic [SCORE_W-1:0] right_score,
  input  logic [DOC_W-1:0]   right_doc,
  output logic               ahead,
  output logic               gt,
  output logic [SCORE_W-1:0] score_nxt,
  output logic [SCORE_W-1:0] score_r,
  output logic [DOC_W-1:0]   doc_r
);

  logic [DOC_W-1:0] doc_nxt;

  // Offered word ranks ahead of this slot; empty slots rank last.
  assign gt    = item_score > score_r;
  assign ahead = !occupied || gt || ((item_score == score_r) && (item_doc < doc_r));

  always_comb begin
    score_nxt = score_r;
    doc_nxt   = doc_r;
    if (ctl.drain_shift) begin
      score_nxt = right_score;
      doc_nxt   = right_doc;
    end else if (ctl.ins_en && ahead) begin
      if (left_ahead) begin
        score_nxt = left_score;
        doc_nxt   = left_doc;
      end else begin
        score_nxt = item_score;
        doc_nxt   = item_doc;
      end
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    doc_r   <= doc_nxt;
  end

endmodule

@@ hw/rtl/top_k_score_selector.sv @@
// ----------------------------------------------------------------------------
// top_k_score_selector
// Keeps the best keep_count scored documents in a sorted chain of cells and
// drains them best first on request.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------------------------------
//  in_     | in  | in_valid / in_ready  | in_word_t: action, doc, score, live
//  out_    | out | out_valid / out_ready| out_word_t: entry, threshold, flags
//  cfg_    | in  | cfg_valid / cfg_ready| keep_count, 5 bits, always ready
//
//  For an offer, the chain compares and inserts in the accept cycle and its
//  result word sits in the output register the next cycle, so offers stream
//  at one word per cycle while idle and the output side keeps up.
//  A drain of an empty store answers with one closing marker word like an
//  offer; otherwise one word leaves the head cell per cycle as the chain
//  shifts toward it, pausing while the output stalls.
//  Reset (rst_n low, synchronous) empties the store, clears the threshold
//  and sets keep_count to 10; cell contents are not cleared.
//  A stalled output holds its word; no new input word is taken until the
//  output register is free, and a drain pauses while out_ready is low.
//
module top_k_score_selector
  import tksel_pkg::*;
#(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t           state_r,     state_nxt;
  logic [CW-1:0]    held_r,      held_nxt;
  logic [SCORE_W-1:0] floor_r,   floor_nxt;
  logic [CFG_W-1:0] keep_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r,  out_data_nxt;

  logic [CW-1:0]    eff_keep;
  logic [CW-1:0]    new_held;
  logic             out_free;
  logic             in_fire;
  logic             drain_emit;
  logic             full;
  logic             min_gt;
  logic             accept_offer;
  logic [SCORE_W-1:0] floor_cand;
  cell_ctl_t        ctl;

  logic [MAX_KEEP-1:0] cell_ahead;
  logic [MAX_KEEP-1:0] cell_gt;
  logic [MAX_KEEP-1:0] cell_tail;
  logic [MAX_KEEP-1:0] cell_new_tail;
  logic [SCORE_W-1:0]  cell_score     [MAX_KEEP];
  logic [SCORE_W-1:0]  cell_score_nxt [MAX_KEEP];
  logic [DOC_W-1:0]    cell_doc       [MAX_KEEP];

  // ---- cell chain: slot 0 holds the best entry ----
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic               l_ahead;
    logic [SCORE_W-1:0] l_score, r_score;
    logic [DOC_W-1:0]   l_doc,   r_doc;

    if (i == 0) begin : g_head
      assign l_ahead = 1'b0;
      assign l_score = in_data.doc_score;
      assign l_doc   = in_data.doc_number;
    end else begin : g_body
      assign l_ahead = cell_ahead[i-1];
      assign l_score = cell_score[i-1];
      assign l_doc   = cell_doc[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign r_score = cell_score[i];
      assign r_doc   = cell_doc[i];
    end else begin : g_inner
      assign r_score = cell_score[i+1];
      assign r_doc   = cell_doc[i+1];
    end

    // Slot marks for the current lowest entry and the lowest after insert.
    assign cell_tail[i]     = (held_r == CW'(i + 1));
    assign cell_new_tail[i] = (new_held == CW'(i + 1));

    tksel_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CW'(i) < held_r),
      .item_score  (in_data.doc_score),
      .item_doc    (in_data.doc_number),
      .left_ahead  (l_ahead),
      .left_score  (l_score),
      .left_doc    (l_doc),
      .right_score (r_score),
      .right_doc   (r_doc),
      .ahead       (cell_ahead[i]),
      .gt          (cell_gt[i]),
      .score_nxt   (cell_score_nxt[i]),
      .score_r     (cell_score[i]),
      .doc_r       (cell_doc[i])
    );
  end

  // ---- effective keep count: 0 acts as 1, clamp to store depth ----
  always_comb begin
    if (keep_r == '0) begin
      eff_keep = CW'(1);
    end else if (KW'(keep_r) > KW'(MAX_KEEP)) begin
      eff_keep = CW'(MAX_KEEP);
    end else begin
      eff_keep = CW'(keep_r);
    end
  end

  // ---- admission and new floor ----
  assign full     = held_r >= eff_keep;
  assign min_gt   = |(cell_gt & cell_tail);
  assign new_held = full ? held_r : held_r + CW'(1);

  always_comb begin
    floor_cand = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      floor_cand = floor_cand | (cell_score_nxt[i] & {SCORE_W{cell_new_tail[i]}});
    end
  end

  // ---- handshake ----
  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_valid && in_ready;
  assign drain_emit   = (state_r == ST_DRAIN) && out_free;
  assign accept_offer = in_data.doc_live && (!full || ((held_r != '0) && min_gt));

  assign ctl.ins_en      = in_fire && (in_data.action == ACT_OFFER) && accept_offer;
  assign ctl.drain_shift = drain_emit;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    floor_nxt     = floor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      out_data_nxt = '{out_doc: '0, out_score: '0, threshold: '0,
                       accepted: 1'b0, is_entry: 1'b0, last: 1'b1};
      if (in_data.action == ACT_OFFER) begin
        // Insert in place; raise the floor once the store reaches keep count.
        if (ctl.ins_en) begin
          held_nxt = new_held;
          if (new_held >= eff_keep) begin
            floor_nxt = floor_cand;
          end
        end
        out_valid_nxt          = 1'b1;
        out_data_nxt.threshold = ctl.ins_en && (new_held >= eff_keep) ? floor_cand : floor_r;
        out_data_nxt.accepted  = ctl.ins_en;
      end else begin
        // Drain: clear the floor now; an empty store answers with one marker.
        floor_nxt = '0;
        if (held_r == '0) begin
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
    end

    if (drain_emit) begin
      // Pop the head cell; the held count doubles as the remaining count.
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_doc: cell_doc[0], out_score: cell_score[0], threshold: '0,
                        accepted: 1'b0, is_entry: 1'b1, last: (held_r == CW'(1))};
      held_nxt      = held_r - CW'(1);
      if (held_r == CW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      floor_r     <= '0;
      keep_r      <= KEEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      floor_r     <= floor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        keep_r <= cfg_data;
      end
    end
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hw/rtl/tksel_chk.sv @@
// ----------------------------------------------------------------------------
// tksel_chk
// Port-level checks of the top-k score selector, bound to the top level.
// ----------------------------------------------------------------------------
module tksel_chk
  import tksel_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Never take a word while a stalled result occupies the output.
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid && !out_ready))
    else $error("input taken while output stalled");

  // An offer answers in the next cycle with one closing, non-entry word.
  a_offer_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.action == ACT_OFFER)) |=>
      (out_valid && out_data.last && !out_data.is_entry))
    else $error("offer did not produce its result word");

  // Drained entries carry no accept flag and a cleared threshold.
  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_entry) |-> (!out_data.accepted && (out_data.threshold == '0)))
    else $error("drained entry with offer fields set");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output word changed while stalled");

endmodule

bind top_k_score_selector tksel_chk u_tksel_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
